// ===== rtl/mhpq_pkg.sv =====
// Package: shared constants, status codes and cell interface types for the min-heap queue.
`default_nettype none
package mhpq_pkg;

  // Default queue depth and key width
  localparam int HEAP_DEPTH = 16;
  localparam int KEY_W      = 32;
  localparam int ENTRIES_W  = 5;
  localparam int STATUS_W   = 2;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
  } mhpq_cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic             gt;     // new key sorts before this cell's key
    logic [KEY_W-1:0] key;
  } mhpq_link_t;

endpackage
`default_nettype wire

// ===== rtl/mhpq_cell.sv =====
// Module: one cell of the sorted key chain; holds one key and shifts with its neighbors.
`default_nettype none
module mhpq_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mhpq_pkg::mhpq_cmd_t cmd,
  input  mhpq_pkg::mhpq_link_t prev_lnk,
  input  mhpq_pkg::mhpq_link_t next_lnk,
  output mhpq_pkg::mhpq_link_t lnk
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [mhpq_pkg::KEY_W-1:0] key_r;
  logic [mhpq_pkg::KEY_W-1:0] key_nxt;
  logic                      gt;

  // New key goes ahead of an empty cell or a strictly larger key
  assign gt = !valid_r || ($signed(cmd.key) < $signed(key_r));

  assign lnk.valid = valid_r;
  assign lnk.gt    = gt;
  assign lnk.key   = key_r;

  // Insert: shift right from the insertion point; remove: shift left
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (cmd.ins && gt) begin
      if (prev_lnk.gt) begin
        valid_nxt = prev_lnk.valid;
        key_nxt   = prev_lnk.key;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = cmd.key;
      end
    end else if (cmd.rem) begin
      valid_nxt = next_lnk.valid;
      key_nxt   = next_lnk.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Key payload needs no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/min_heap_priority_queue.sv =====
// Top level: bounded min priority queue of signed keys on a chain of sorted cells.
//
// Bounded priority queue of HEAP_DEPTH signed 32-bit keys. Each item on the input
// stream is an insert (in_tuser = 0, key in in_tdata) or a remove-minimum (in_tuser = 1),
// and each gives exactly one result item: the removed key, a key-valid flag, a status
// code (0 ok, 1 insert dropped because full, 2 remove on empty) and the number of keys
// held afterwards. Keys sit in a row of HEAP_DEPTH cells kept in ascending order; an
// insert is compared against every cell at once and shifts the larger keys one cell to
// the right, a remove shifts the whole row one cell to the left. One item is taken per
// clock cycle and its result enters the output register in the next cycle; the input
// keeps accepting while that register is free or being emptied in the same cycle. The
// cycle time is set by one 32-bit signed compare per cell plus the shift selection. No
// clearing pass is needed after reset.
`default_nettype none
module min_heap_priority_queue #(
  parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  // input item stream
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,   // [31:0] key_in
  input  wire        in_tuser,   // [0] func
  // result item stream
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [39:0] out_tdata, // [31:0] min_key, [33:32] status, [38:34] entries, pad
  output logic       out_tuser   // [0] key_valid
);

  localparam int CW = $clog2(HEAP_DEPTH + 1);

  mhpq_pkg::mhpq_cmd_t  cmd;
  mhpq_pkg::mhpq_link_t lnk  [HEAP_DEPTH];
  mhpq_pkg::mhpq_link_t edge_nil;

  logic          in_acc;
  logic          full;
  logic          empty;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW+mhpq_pkg::ENTRIES_W-1:0] cnt_ext;

  logic                              out_valid_r;
  logic [mhpq_pkg::KEY_W-1:0]        min_key_r;
  logic [mhpq_pkg::KEY_W-1:0]        min_key_nxt;
  logic                              key_valid_r;
  logic                              key_valid_nxt;
  logic [mhpq_pkg::STATUS_W-1:0]     status_r;
  logic [mhpq_pkg::STATUS_W-1:0]     status_nxt;
  logic [mhpq_pkg::ENTRIES_W-1:0]    entries_r;

  // Handshake
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (cnt_r == CW'(HEAP_DEPTH));
  assign empty     = (cnt_r == '0);

  // Command to the cell row
  assign cmd.ins = in_acc && (in_tuser == mhpq_pkg::FUNC_INSERT) && !full;
  assign cmd.rem = in_acc && (in_tuser == mhpq_pkg::FUNC_REMOVE) && !empty;
  assign cmd.key = in_tdata;

  // Chain ends: nothing shifts in from outside
  assign edge_nil.valid = 1'b0;
  assign edge_nil.gt    = 1'b0;
  assign edge_nil.key   = '0;

  // Row of cells, ascending from cell 0
  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    mhpq_pkg::mhpq_link_t prv;
    mhpq_pkg::mhpq_link_t nxt;
    if (i == 0) begin : g_first
      assign prv = edge_nil;
    end else begin : g_mid_p
      assign prv = lnk[i-1];
    end
    if (i == HEAP_DEPTH - 1) begin : g_last
      assign nxt = edge_nil;
    end else begin : g_mid_n
      assign nxt = lnk[i+1];
    end
    mhpq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .prev_lnk (prv),
      .next_lnk (nxt),
      .lnk      (lnk[i])
    );
  end

  // Entry count and result fields
  always_comb begin
    cnt_nxt       = cnt_r;
    min_key_nxt   = '0;
    key_valid_nxt = 1'b0;
    status_nxt    = mhpq_pkg::STATUS_OK;
    if (in_tuser == mhpq_pkg::FUNC_INSERT) begin
      if (full) begin
        status_nxt = mhpq_pkg::STATUS_FULL;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = mhpq_pkg::STATUS_EMPTY;
      end else begin
        cnt_nxt       = cnt_r - CW'(1);
        min_key_nxt   = lnk[0].key;
        key_valid_nxt = 1'b1;
      end
    end
  end

  assign cnt_ext = {{mhpq_pkg::ENTRIES_W{1'b0}}, cnt_nxt};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      min_key_r   <= min_key_nxt;
      key_valid_r <= key_valid_nxt;
      status_r    <= status_nxt;
      entries_r   <= cnt_ext[mhpq_pkg::ENTRIES_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, entries_r, status_r, min_key_r};
  assign out_tuser  = key_valid_r;

endmodule
`default_nettype wire

// ===== dv/min_heap_priority_queue_tb.sv =====
// Testbench for the min-heap priority queue: streams insert/remove items, checks every result.
`timescale 1ns / 100ps

module min_heap_priority_queue_tb;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 28;
  localparam int REPORT_MAX   = 10;

  // One result item as the block returns it
  typedef struct packed {
    logic [31:0] min_key;
    logic        key_valid;
    logic [1:0]  status;
    logic [4:0]  entries;
  } heap_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = mhpq_pkg::FUNC_INSERT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  // Shadow heap and the results it predicts
  logic signed [31:0] heap_keys [mhpq_pkg::HEAP_DEPTH];
  int                 heap_count = 0;
  heap_result_t       pending_results [$];

  // Run flags and counters
  bit steady_flow = 1'b0;
  int hold_request = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int full_drops = 0;
  int empty_removes = 0;
  int keys_removed = 0;

  min_heap_priority_queue #(
    .HEAP_DEPTH(mhpq_pkg::HEAP_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one operation to the shadow heap and return the result it should give
  function automatic heap_result_t apply_heap_op(logic func, logic [31:0] key);
    heap_result_t       res;
    int                 pos;
    int                 parent;
    int                 left;
    int                 right;
    int                 pick;
    bit                 done;
    logic signed [31:0] tmp;
    res = '0;
    res.status = mhpq_pkg::STATUS_OK;
    if (func == mhpq_pkg::FUNC_INSERT) begin
      if (heap_count >= mhpq_pkg::HEAP_DEPTH) begin
        res.status = mhpq_pkg::STATUS_FULL;
        full_drops++;
      end else begin
        pos = heap_count;
        heap_keys[pos] = key;
        heap_count++;
        done = 1'b0;
        // sift up while the parent is strictly greater
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_keys[parent] > heap_keys[pos]) begin
            tmp = heap_keys[parent];
            heap_keys[parent] = heap_keys[pos];
            heap_keys[pos] = tmp;
            pos = parent;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (heap_count == 0) begin
        res.status = mhpq_pkg::STATUS_EMPTY;
        empty_removes++;
      end else begin
        res.min_key = heap_keys[0];
        res.key_valid = 1'b1;
        keys_removed++;
        heap_count--;
        heap_keys[0] = heap_keys[heap_count];
        pos = 0;
        done = 1'b0;
        // sift down toward the smaller child, left on a tie
        while (!done) begin
          left = pos * 2 + 1;
          right = pos * 2 + 2;
          if (left >= heap_count) begin
            done = 1'b1;
          end else begin
            pick = left;
            if (right < heap_count && heap_keys[left] > heap_keys[right]) pick = right;
            if (heap_keys[pos] > heap_keys[pick]) begin
              tmp = heap_keys[pos];
              heap_keys[pos] = heap_keys[pick];
              heap_keys[pick] = tmp;
              pos = pick;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
    end
    res.entries = 5'(heap_count);
    return res;
  endfunction

  task automatic log_mismatch(string what, heap_result_t want, heap_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("[%0t] %s: expected key=%h valid=%b status=%0d entries=%0d", $realtime, what,
               want.min_key, want.key_valid, want.status, want.entries);
      $display("[%0t]   got      key=%h valid=%b status=%0d entries=%0d", $realtime,
               got.min_key, got.key_valid, got.status, got.entries);
    end
  endtask

  // Predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    heap_result_t want;
    heap_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_heap_op(in_tuser, in_tdata));
        items_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got.min_key = out_tdata[31:0];
        got.status = out_tdata[33:32];
        got.entries = out_tdata[38:34];
        got.key_valid = out_tuser;
        if (pending_results.size() == 0) begin
          log_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got !== want) log_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Result side: random stalls, steady stretches and long hold-offs on request
  always @(posedge clk) begin
    int hold_left;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (steady_flow) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it
  task automatic send_item(logic func, logic [31:0] key);
    int gap;
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(3, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Mostly full-range keys, with extremes and a narrow band to force ties
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_remove_on_empty();
    send_item(mhpq_pkg::FUNC_REMOVE, 32'hFFFF_FFFF);
  endtask

  task automatic test_key_extremes();
    send_item(mhpq_pkg::FUNC_INSERT, 32'h0000_0000);
    send_item(mhpq_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
    send_item(mhpq_pkg::FUNC_INSERT, 32'h8000_0000);
    send_item(mhpq_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
    send_item(mhpq_pkg::FUNC_INSERT, 32'h0000_0001);
    // removes come back in signed order; the key field is ignored
    repeat (5) send_item(mhpq_pkg::FUNC_REMOVE, $urandom());
    send_item(mhpq_pkg::FUNC_REMOVE, 32'h8000_0000);
  endtask

  task automatic test_equal_keys();
    send_item(mhpq_pkg::FUNC_INSERT, 32'd3);
    send_item(mhpq_pkg::FUNC_INSERT, 32'd3);
    send_item(mhpq_pkg::FUNC_INSERT, 32'hFFFF_FFFE);
    send_item(mhpq_pkg::FUNC_INSERT, 32'd3);
    send_item(mhpq_pkg::FUNC_INSERT, 32'hFFFF_FFFE);
    repeat (5) send_item(mhpq_pkg::FUNC_REMOVE, 32'h0);
  endtask

  // Overfill so inserts get dropped, then overdrain so removes find it empty
  task automatic test_fill_and_drain();
    repeat (mhpq_pkg::HEAP_DEPTH + 2) send_item(mhpq_pkg::FUNC_INSERT, pick_key());
    repeat (mhpq_pkg::HEAP_DEPTH + 2) send_item(mhpq_pkg::FUNC_REMOVE, $urandom());
  endtask

  // Receiver stops for a long stretch while items keep coming
  task automatic test_backpressure();
    steady_flow = 1'b1;
    hold_request = 80;
    repeat (24) begin
      if ($urandom_range(99) < 60) send_item(mhpq_pkg::FUNC_INSERT, pick_key());
      else send_item(mhpq_pkg::FUNC_REMOVE, $urandom());
    end
    steady_flow = 1'b0;
  endtask

  // Batches that lean toward filling, balancing or draining the queue
  task automatic test_random_mix(int batches, int batch_len);
    int insert_pct;
    for (int b = 0; b < batches; b++) begin
      steady_flow = (b < 4);
      case (b % 3)
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      repeat (batch_len) begin
        if ($urandom_range(99) < insert_pct) send_item(mhpq_pkg::FUNC_INSERT, pick_key());
        else send_item(mhpq_pkg::FUNC_REMOVE, $urandom());
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_remove_on_empty();
    test_key_extremes();
    test_equal_keys();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix(12, 40);
    in_tvalid <= 1'b0;

    // let the last results drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items, %0d results checked: %0d keys removed, %0d full drops,",
             items_accepted, results_checked, keys_removed, full_drops);
    $display("%0d removes on empty, extremes, ties and a long output stall",
             empty_removes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
